// ===== rtl/ssi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_pkg: shared definitions for the sorted set core
// Word widths, command codes, default capacity and the compare result type.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int VALUE_W          = 32;
  localparam int CMD_W            = 2;
  localparam int SIZE_W           = 5;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Outcome of the shared signed compare of a stored entry against the key.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage
`default_nettype wire

// ===== rtl/ssi_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/ssi_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_cmp: shared signed comparator
// Compares one stored word against the search key in two's complement order.
// ----------------------------------------------------------------------------
module ssi_cmp (
  input  wire logic signed [ssi_pkg::VALUE_W-1:0] entry,
  input  wire logic signed [ssi_pkg::VALUE_W-1:0] key,
  output ssi_pkg::cmp_res_t                       res
);

  import ssi_pkg::*;

  always_comb begin
    res.lt = (entry < key);
    res.eq = (entry == key);
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_set_insert_query_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_insert_query_core: bounded ordered set of signed 32-bit values
// Insert, query and clear commands over a sorted RAM, one word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, cmd, value) carries one command
//   word: insert, query or clear. The output channel (out_valid, out_stall,
//   found, inserted, full_drop, size_now) returns exactly one result word per
//   command, in command order.
//   A command is taken only while the sequencer is idle; in_stall is high for
//   the whole time a command is in progress.
//   A clear or an unused code goes straight to the finishing step, which
//   loads the output register and returns the sequencer to idle.
//   An insert or query scans the sorted RAM from the bottom with one shared
//   comparator, with a registered RAM read and then a compare for each entry
//   below the key's position. The scan ends at the count or at the first
//   entry not below the key. A new insert then moves every held entry at or
//   above that position up by one (read, then write) and stores the new
//   value at that position. The finishing step then loads the result into
//   the output register and returns the sequencer to idle.
//   Reset empties the set at once: the count goes to zero and no clearing
//   pass runs, since only entries below the count are ever read.
//   When the receiver stalls, the finished result waits in the output
//   register; the next command may already be accepted and worked on, and
//   it waits at its last step until the output register is free.
// ----------------------------------------------------------------------------
module sorted_set_insert_query_core #(
  parameter int CAPACITY = ssi_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic        [ssi_pkg::CMD_W-1:0]   cmd,
  input  wire logic signed [ssi_pkg::VALUE_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    found,
  output logic                                    inserted,
  output logic                                    full_drop,
  output logic             [ssi_pkg::SIZE_W-1:0]  size_now
);

  import ssi_pkg::*;

  // Index width addresses the RAM; count width also holds CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SCAN_RD  = 7'b0000010,
    ST_SCAN_CMP = 7'b0000100,
    ST_SHIFT_RD = 7'b0001000,
    ST_SHIFT_WR = 7'b0010000,
    ST_PLACE    = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [CMD_W-1:0]          cmd_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CW-1:0]             pos, pos_next;       // scan position (lower bound)
  logic [CW-1:0]             idx, idx_next;       // shift destination
  logic [CW-1:0]             count, count_next;   // number of held entries
  logic                      found_q, found_next;
  logic                      ins_q, ins_next;
  logic                      drop_q, drop_next;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;

  cmp_res_t                  cmp;
  logic [CW-1:0]             idx_dec;
  logic                      scan_done;
  logic                      scan_hit;
  logic                      load_out;
  logic                      accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_dec  = idx - CW'(1);

  // Sorted storage: entry k holds the k-th smallest value for k below count.
  ssi_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The one comparator, reused on every scan step.
  ssi_cmp u_cmp (
    .entry (ram_rdata),
    .key   (value_q),
    .res   (cmp)
  );

  always_comb begin
    state_next = state;
    pos_next   = pos;
    idx_next   = idx;
    count_next = count;
    found_next = found_q;
    ins_next   = ins_q;
    drop_next  = drop_q;
    ram_we     = 1'b0;
    ram_waddr  = idx[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = pos[AW-1:0];
    scan_done  = 1'b0;
    scan_hit   = 1'b0;
    load_out   = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          pos_next   = '0;
          found_next = 1'b0;
          ins_next   = 1'b0;
          drop_next  = 1'b0;
          case (cmd)
            CMD_INSERT, CMD_QUERY: begin
              state_next = ST_SCAN_RD;
            end
            CMD_CLEAR: begin
              count_next = '0;
              state_next = ST_FINISH;
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        // The read of entry pos is issued here; at the count the scan ends with no compare.
        if (pos == count) begin
          scan_done = 1'b1;
        end else begin
          state_next = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (cmp.lt) begin
          pos_next   = pos + CW'(1);
          state_next = ST_SCAN_RD;
        end else begin
          scan_done = 1'b1;
          scan_hit  = cmp.eq;
        end
      end
      ST_SHIFT_RD: begin
        ram_raddr  = idx_dec[AW-1:0];
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        // Entry idx-1 moves up into idx.
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        ram_wdata = ram_rdata;
        idx_next  = idx_dec;
        if (idx_dec == pos) begin
          state_next = ST_PLACE;
        end else begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_PLACE: begin
        ram_we     = 1'b1;
        ram_waddr  = pos[AW-1:0];
        ram_wdata  = value_q;
        count_next = count + CW'(1);
        ins_next   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // End of scan: pos is the lower bound and scan_hit tells whether the
    // value is already held.
    if (scan_done) begin
      found_next = scan_hit;
      if (cmd_q == CMD_QUERY || scan_hit) begin
        state_next = ST_FINISH;
      end else if (count == CW'(CAPACITY)) begin
        drop_next  = 1'b1;
        state_next = ST_FINISH;
      end else begin
        idx_next   = count;
        state_next = (count == pos) ? ST_PLACE : ST_SHIFT_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      value_q <= value;
    end
    pos     <= pos_next;
    idx     <= idx_next;
    found_q <= found_next;
    ins_q   <= ins_next;
    drop_q  <= drop_next;
  end

  // Output register: holds a finished result word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found     <= found_q;
      inserted  <= ins_q;
      full_drop <= drop_q;
      size_now  <= SIZE_W'(count);
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A new result word only appears from the finishing step.
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result word raised outside the finishing step");

  // Moves and placements never write past the last RAM entry.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT_WR || state == ST_PLACE) |-> (idx < CW'(CAPACITY)))
    else $error("RAM write beyond capacity");

  // An element is added only when it was not already present and the set has room.
  a_insert_new: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE) |-> (!found_q && !drop_q && count < CW'(CAPACITY)))
    else $error("placement of a held value or into a full set");

endmodule
`default_nettype wire
